FILE: rtl/core/echo_distance_kalman_filter_assert.svh
// Assertion macros used by the echo distance Kalman filter checker.
`ifndef ECHO_DISTANCE_KALMAN_FILTER_ASSERT_SVH
`define ECHO_DISTANCE_KALMAN_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define EDK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("edk assertion failed");

// Next-cycle implication, disabled while in reset.
`define EDK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("edk assertion failed");

`endif

FILE: rtl/core/edk_pkg.sv
// Package with types, constants and helpers of the echo distance Kalman filter.
package edk_pkg;

	localparam int FRAC_BITS    = 16;
	localparam int PULSE_BITS   = 16;
	localparam int GAIN_BITS    = 16;
	localparam int GAIN_W       = GAIN_BITS + 1;
	localparam int NOISE_BITS   = 24;
	localparam int EST_BITS     = 28;
	localparam int COV_BITS     = 32;
	localparam int CFG_IDX_BITS = 8;

	localparam int RAW_RECIP_BITS = 32;
	localparam int RAW_PROD_BITS  = PULSE_BITS + RAW_RECIP_BITS;
	localparam int RAW_SHIFT      = 21;
	localparam int RAW_Q_BITS     = RAW_PROD_BITS - RAW_SHIFT;
	localparam int GAIN_STEPS   = GAIN_W;
	localparam int DQ_BITS      = GAIN_STEPS;
	localparam int REM_BITS     = COV_BITS + 1;
	localparam int CNT_BITS     = $clog2(GAIN_STEPS);
	localparam int DIFF_BITS    = EST_BITS + 1;
	localparam int PEST_BITS    = DIFF_BITS + GAIN_W + 1;
	localparam int PERR_BITS    = GAIN_W + COV_BITS;
	localparam int SUM_BITS     = 34;

	// (p << 16) / 58 equals (p * ceil(2^36 / 29)) >> 21 for every 16-bit p
	localparam logic [RAW_RECIP_BITS-1:0]  RAW_RECIP = 32'd2369637129;

	localparam logic signed [EST_BITS-1:0] EST_LO   = -28'sd65536;
	localparam logic signed [EST_BITS-1:0] EST_HI   = 28'sd134217727;
	localparam logic signed [EST_BITS-1:0] RAW_BIAS = 28'sd65536;
	localparam logic [GAIN_W-1:0]          GAIN_ONE = 17'd65536;

	localparam logic [NOISE_BITS-1:0]      PN_RESET = 24'd327680;
	localparam logic [NOISE_BITS-1:0]      MN_RESET = 24'd32768;
	localparam logic [NOISE_BITS-1:0]      IE_RESET = 24'd6554;
	localparam logic signed [EST_BITS-1:0] IS_RESET = 28'sd6553600;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_PROCESS_NOISE    = 8'd0,
		REG_MEASURE_NOISE    = 8'd1,
		REG_INITIAL_ERROR    = 8'd2,
		REG_INITIAL_ESTIMATE = 8'd3
	} edk_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN_LOAD,
		ST_GAIN_DIV,
		ST_MUL_EST,
		ST_MUL_ERR,
		ST_COMMIT,
		ST_WRITE
	} edk_state_t;

	typedef struct packed {
		logic take_item;
		logic div_step;
		logic gain_load;
		logic mul_est;
		logic mul_err;
		logic commit;
		logic emit;
	} edk_cmd_t;

	typedef struct packed {
		logic echo_valid;
		logic out_busy;
	} edk_stat_t;

	function automatic logic signed [EST_BITS-1:0] clamp_est(input logic signed [SUM_BITS-1:0] v);
		logic signed [EST_BITS-1:0] r;
		if (v < SUM_BITS'(EST_LO))
			r = EST_LO;
		else if (v > SUM_BITS'(EST_HI))
			r = EST_HI;
		else
			r = v[EST_BITS-1:0];
		return r;
	endfunction

endpackage

FILE: rtl/core/edk_if.sv
// Valid/ready channel interfaces for items, results and register writes.
interface edk_item_if import edk_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [PULSE_BITS-1:0] pulse_us;
	logic                  echo_valid;

	modport source (output valid, pulse_us, echo_valid, input ready);
	modport sink (input valid, pulse_us, echo_valid, output ready);
endinterface

interface edk_result_if import edk_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [EST_BITS-1:0] filtered_distance;
	logic signed [EST_BITS-1:0] raw_distance;
	logic [GAIN_W-1:0]          gain;
	logic                       updated;

	modport source (output valid, filtered_distance, raw_distance, gain, updated, input ready);
	modport sink (input valid, filtered_distance, raw_distance, gain, updated, output ready);
endinterface

interface edk_cfg_if import edk_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [EST_BITS-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/edk_ctrl.sv
// Controller state machine sequencing division, multiplies and result write.
module edk_ctrl import edk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  edk_stat_t stat,
	output edk_cmd_t  cmd
);

	edk_state_t          state_q, state_d;
	logic [CNT_BITS-1:0] cnt_q;
	logic                last_gain;

	assign last_gain = (cnt_q == CNT_BITS'(GAIN_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_GAIN_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_valid)
					state_d = stat.echo_valid ? ST_GAIN_LOAD : ST_WRITE;
			end
			ST_GAIN_LOAD: state_d = ST_GAIN_DIV;
			ST_GAIN_DIV: begin
				if (last_gain)
					state_d = ST_MUL_EST;
			end
			ST_MUL_EST: state_d = ST_MUL_ERR;
			ST_MUL_ERR: state_d = ST_COMMIT;
			ST_COMMIT:  state_d = ST_WRITE;
			ST_WRITE: begin
				if (!stat.out_busy)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready    = 1'b1;
				cmd.take_item = item_valid;
			end
			ST_GAIN_LOAD: cmd.gain_load = 1'b1;
			ST_GAIN_DIV:  cmd.div_step  = 1'b1;
			ST_MUL_EST:   cmd.mul_est   = 1'b1;
			ST_MUL_ERR:   cmd.mul_err   = 1'b1;
			ST_COMMIT:    cmd.commit    = 1'b1;
			ST_WRITE:     cmd.emit      = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

FILE: rtl/core/edk_datapath.sv
// Datapath: registers, serial divider, multipliers, filter state and result register.
module edk_datapath import edk_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  edk_cmd_t                   cmd,
	output edk_stat_t                  stat,
	input  logic [PULSE_BITS-1:0]      pulse_us,
	input  logic                       echo_valid,
	input  logic                       cfg_we,
	input  logic [CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [EST_BITS-1:0]        cfg_data,
	output logic                       res_valid,
	input  logic                       res_ready,
	output logic signed [EST_BITS-1:0] filtered_distance,
	output logic signed [EST_BITS-1:0] raw_distance,
	output logic [GAIN_W-1:0]          gain,
	output logic                       updated
);

	logic [NOISE_BITS-1:0]      pn_q, mn_q, ie_q;
	logic signed [EST_BITS-1:0] is_q;
	logic signed [EST_BITS-1:0] estimate_q;
	logic [COV_BITS-1:0]        error_cov_q;

	logic                       valid_q;
	logic [COV_BITS-1:0]        pred_q;
	logic [RAW_PROD_BITS-1:0]   raw_prod_q;
	logic signed [EST_BITS-1:0] raw_q;
	logic [GAIN_W-1:0]          gain_q;
	logic                       den_zero_q;
	logic [REM_BITS-1:0]        rem_q, div_d_q;
	logic [DQ_BITS-1:0]         dq_q;
	logic signed [PEST_BITS-1:0] prod_est_q;
	logic [PERR_BITS-1:0]       prod_err_q;

	logic                       out_valid_q;
	logic signed [EST_BITS-1:0] out_est_q, out_raw_q;
	logic [GAIN_W-1:0]          out_gain_q;
	logic                       out_upd_q;

	logic [REM_BITS:0]          rem_shift, rem_sub;
	logic                       rem_ge;
	logic [COV_BITS:0]          pred_sum;
	logic [COV_BITS-1:0]        pred_sat;
	logic [REM_BITS-1:0]        den;
	logic [GAIN_W-1:0]          gain_res;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [SUM_BITS-1:0]  est_sum;
	logic [NOISE_BITS-1:0]      ie_next;
	logic signed [EST_BITS-1:0] is_next;
	logic                       reload;

	assign pred_sum  = {1'b0, error_cov_q} + (COV_BITS + 1)'(pn_q);
	assign pred_sat  = pred_sum[COV_BITS] ? '1 : pred_sum[COV_BITS-1:0];
	assign den       = {1'b0, pred_q} + REM_BITS'(mn_q);
	assign rem_shift = {rem_q, dq_q[DQ_BITS-1]};
	assign rem_sub   = rem_shift - {1'b0, div_d_q};
	assign rem_ge    = (rem_shift >= {1'b0, div_d_q});
	assign gain_res  = den_zero_q ? '0 : dq_q[GAIN_W-1:0];
	assign diff      = DIFF_BITS'(raw_q) - DIFF_BITS'(estimate_q);
	assign est_sum   = SUM_BITS'(estimate_q) + SUM_BITS'(prod_est_q >>> GAIN_BITS);

	assign stat.echo_valid = echo_valid;
	assign stat.out_busy   = out_valid_q && !res_ready;

	always_comb begin
		ie_next = ie_q;
		is_next = is_q;
		reload  = 1'b0;
		if (cfg_we) begin
			case (cfg_index)
				REG_PROCESS_NOISE:    reload = 1'b1;
				REG_MEASURE_NOISE:    reload = 1'b1;
				REG_INITIAL_ERROR: begin
					reload  = 1'b1;
					ie_next = cfg_data[NOISE_BITS-1:0];
				end
				REG_INITIAL_ESTIMATE: begin
					reload  = 1'b1;
					is_next = $signed(cfg_data);
				end
				default: reload = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pn_q        <= PN_RESET;
			mn_q        <= MN_RESET;
			ie_q        <= IE_RESET;
			is_q        <= IS_RESET;
			estimate_q  <= clamp_est(SUM_BITS'(IS_RESET));
			error_cov_q <= COV_BITS'(IE_RESET);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_PROCESS_NOISE)
				pn_q <= cfg_data[NOISE_BITS-1:0];
			if (cfg_we && cfg_index == REG_MEASURE_NOISE)
				mn_q <= cfg_data[NOISE_BITS-1:0];
			ie_q <= ie_next;
			is_q <= is_next;
			if (reload) begin
				estimate_q  <= clamp_est(SUM_BITS'(is_next));
				error_cov_q <= COV_BITS'(ie_next);
			end else if (cmd.commit) begin
				estimate_q  <= clamp_est(est_sum);
				error_cov_q <= prod_err_q[GAIN_BITS +: COV_BITS];
			end
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			valid_q    <= echo_valid;
			pred_q     <= pred_sat;
			raw_q      <= '0;
			gain_q     <= '0;
			raw_prod_q <= RAW_PROD_BITS'(pulse_us) * RAW_PROD_BITS'(RAW_RECIP);
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? rem_sub[REM_BITS-1:0] : rem_shift[REM_BITS-1:0];
			dq_q  <= {dq_q[DQ_BITS-2:0], rem_ge};
		end else if (cmd.gain_load) begin
			raw_q      <= $signed({1'b0, raw_prod_q[RAW_SHIFT +: RAW_Q_BITS]}) - RAW_BIAS;
			den_zero_q <= (den == '0);
			div_d_q    <= den;
			rem_q      <= REM_BITS'(pred_q[COV_BITS-1:1]);
			dq_q       <= {pred_q[0], (DQ_BITS - 1)'(0)};
		end
		if (cmd.mul_est) begin
			gain_q     <= gain_res;
			prod_est_q <= PEST_BITS'(diff) * $signed({1'b0, gain_res});
		end
		if (cmd.mul_err)
			prod_err_q <= PERR_BITS'(GAIN_ONE - gain_q) * PERR_BITS'(pred_q);
		if (cmd.emit) begin
			out_est_q  <= estimate_q;
			out_raw_q  <= raw_q;
			out_gain_q <= gain_q;
			out_upd_q  <= valid_q;
		end
	end

	assign res_valid         = out_valid_q;
	assign filtered_distance = out_est_q;
	assign raw_distance      = out_raw_q;
	assign gain              = out_gain_q;
	assign updated           = out_upd_q;

endmodule

FILE: rtl/core/echo_distance_kalman_filter.sv
// Top level of the scalar Kalman filter for ultrasonic echo distance.
//
// channel  direction  transaction
// item     sink       pulse_us, echo_valid
// result   source     filtered_distance, raw_distance, gain, updated
// cfg      sink       index, data (register write, always ready)
//
// An echo item passes from acceptance to result in these steps: the reciprocal multiply
// for pulse/58 at acceptance, the divider load, the serial gain division, then two
// multiplies, the state update and the result write. A timeout item goes straight
// to the result write. The next item is taken the cycle after the result is
// written; a result still waiting stalls only the next write.
// Reset is asynchronous, active low, and loads registers and filter state.
module echo_distance_kalman_filter import edk_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	edk_item_if.sink     item,
	edk_result_if.source result,
	edk_cfg_if.sink      cfg
);

	edk_cmd_t  cmd;
	edk_stat_t stat;

	assign cfg.ready = 1'b1;

	edk_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	edk_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.pulse_us          (item.pulse_us),
		.echo_valid        (item.echo_valid),
		.cfg_we            (cfg.valid),
		.cfg_index         (cfg.index),
		.cfg_data          (cfg.data),
		.res_valid         (result.valid),
		.res_ready         (result.ready),
		.filtered_distance (result.filtered_distance),
		.raw_distance      (result.raw_distance),
		.gain              (result.gain),
		.updated           (result.updated)
	);

endmodule

FILE: rtl/core/edk_checker.sv
// Port-level checker for the echo distance Kalman filter, bound to the top level.
`include "echo_distance_kalman_filter_assert.svh"

module edk_checker import edk_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic signed [EST_BITS-1:0] filtered_distance,
	input logic signed [EST_BITS-1:0] raw_distance,
	input logic [GAIN_W-1:0]          gain,
	input logic                       updated
);

	`EDK_ASSERT_NEXT(a_one_in_work, clk, arst_n, item_valid && item_ready, !item_ready)
	`EDK_ASSERT_SAME(a_skip_zero, clk, arst_n, res_valid && !updated, gain == '0 && raw_distance == '0)
	`EDK_ASSERT_SAME(a_gain_max, clk, arst_n, res_valid, gain <= GAIN_ONE)
	`EDK_ASSERT_SAME(a_est_low, clk, arst_n, res_valid, filtered_distance >= EST_LO)
	`EDK_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid)

endmodule

bind echo_distance_kalman_filter edk_checker u_edk_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.item_valid        (item.valid),
	.item_ready        (item.ready),
	.res_valid         (result.valid),
	.res_ready         (result.ready),
	.filtered_distance (result.filtered_distance),
	.raw_distance      (result.raw_distance),
	.gain              (result.gain),
	.updated           (result.updated)
);
